### rtl/core/tscr_pkg.sv
// Shared types and constants for the tempo-synced time CV ramp.
package tscr_pkg;

    localparam int unsigned SR_W    = 18;
    localparam int unsigned BPM_W   = 17;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned DIV_W   = 15;
    localparam int unsigned SPD_W   = 12;
    localparam int unsigned BEAT_W  = 24;
    localparam int unsigned K_W     = 24;
    localparam int unsigned BD_W    = 32;
    localparam int unsigned EFIX_W  = 32;
    localparam int unsigned NUM_W   = 48;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned PER_NUM_W = 40;
    localparam int unsigned IN_W    = 72;
    localparam int unsigned OUT_W   = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_BPM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MS      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MS      = 2'd3;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_BNUM, S_BEAT, S_BEND, S_PLOAD, S_PER, S_PEND,
        S_MUL, S_MEND, S_EDIV, S_EEND, S_CV, S_CDIV, S_CEND, S_OUT
    } t_state;

endpackage

### rtl/core/tempo_synced_time_cv_ramp.sv
// Top level of the tempo-synced time CV ramp with its shared serial divider.
//
//  channel   direction  payload (lowest bit first)
//  s_axis    in         tuser: op; tdata: sync, divisions, host fields
//  m_axis    out        tdata: cv_code, elapsed_ms
//  cfg       in         write enable, index, data
//
// An update transfer is applied at once and leaves the sequencer idle. A tick runs from
// its transfer through setup to a loaded result, skipping the divisions and multiply when
// tempo or division is zero; otherwise up to four long divisions (48, 40, 32 and 48
// steps) and one PHASE_BITS-step multiply run one bit a cycle through the single
// shift/subtract unit. The next transfer can be taken in the cycle after the result
// is loaded.
// Reset is synchronous, active low, and restores configuration, block and sequencer
// state but not the datapath. While a result waits in the output register the
// sequencer holds in its final step; input stays blocked until the tick completes.
module tempo_synced_time_cv_ramp #(
    parameter int unsigned PHASE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // sync_enable, divisions, host_bpm, host_bpm_valid, host_speed,
    // host_speed_valid, host_beat, host_beat_valid
    input  logic [tscr_pkg::IN_W-1:0]     i_s_axis_tdata,
    // op
    input  logic                          i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // cv_code, elapsed_ms
    output logic [tscr_pkg::OUT_W-1:0]    o_m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [tscr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tscr_pkg::SR_W-1:0]     i_cfg_data
);
    import tscr_pkg::*;

    localparam int unsigned PB = PHASE_BITS;
    localparam int unsigned DW = BD_W + PB;
    localparam int unsigned RW = DW + 1;
    localparam int unsigned MW = PB + 16;
    localparam logic [PB-1:0] PMASK = {PB{1'b1}};

    // input fields
    logic                in_sync;
    logic [DIV_W-1:0]    in_div;
    logic [BPM_W-1:0]    in_bpm;
    logic                in_bpm_v;
    logic [SPD_W-1:0]    in_spd;
    logic                in_spd_v;
    logic [BEAT_W-1:0]   in_beat;
    logic                in_beat_v;

    assign in_sync   = i_s_axis_tdata[0];
    assign in_div    = i_s_axis_tdata[15:1];
    assign in_bpm    = i_s_axis_tdata[32:16];
    assign in_bpm_v  = i_s_axis_tdata[33];
    assign in_spd    = i_s_axis_tdata[45:34];
    assign in_spd_v  = i_s_axis_tdata[46];
    assign in_beat   = i_s_axis_tdata[70:47];
    assign in_beat_v = i_s_axis_tdata[71];

    t_state r_state, n_state;

    // configuration
    logic [SR_W-1:0]   r_sr;
    logic [BPM_W-1:0]  r_manual;
    logic [MS_W-1:0]   r_min, r_max;

    // block state
    logic [BPM_W-1:0]  r_bpm;
    logic [SPD_W-1:0]  r_speed, r_last_speed;
    logic [BEAT_W-1:0] r_beat;
    logic              r_last_sync;
    logic [DIV_W-1:0]  r_div;
    logic [PB-1:0]     r_phase;

    // working registers
    logic              r_chg;
    logic [K_W-1:0]    r_k;
    logic [BD_W-1:0]   r_bd;
    logic [BEAT_W-1:0] r_pd;
    logic [PB-1:0]     r_period;
    logic [MW-1:0]     r_m;
    logic [EFIX_W-1:0] r_efix;
    logic              r_sat;
    logic [MS_W-1:0]   r_cv;

    // shared shift/subtract unit
    logic [RW-1:0]     r_rem;
    logic [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]  r_quo;
    logic [DW-1:0]     r_dvs;
    logic [CNT_W-1:0]  r_cnt;

    logic              r_ovalid;
    logic [OUT_W-1:0]  r_odata;

    logic              in_xfer;
    logic              out_free;
    logic [RW-1:0]     st_t;
    logic              st_ge;
    logic [RW-1:0]     st_rem;
    logic [NUM_W-1:0]  st_quo;
    logic [RW-1:0]     mul_acc;
    logic [PB-1:0]     per_q;
    logic [EFIX_W-1:0] lo, hi, span;
    logic [NUM_W-1:0]  cv_num;
    logic [PB:0]       ph_inc;

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_ovalid || i_m_axis_tready;

    // one divide step or one multiply-accumulate step
    always_comb begin
        st_t    = {r_rem[RW-2:0], r_num[NUM_W-1]};
        st_ge   = st_t >= RW'(r_dvs);
        st_rem  = st_ge ? (st_t - RW'(r_dvs)) : st_t;
        st_quo  = {r_quo[NUM_W-2:0], st_ge};
        mul_acc = {r_rem[RW-2:0], 1'b0} + (r_num[NUM_W-1] ? RW'(r_dvs) : RW'(0));
    end

    // clamp the period quotient: zero becomes one, overflow saturates
    always_comb begin
        if (r_quo == '0) begin
            per_q = PB'(1);
        end else if (r_quo > NUM_W'(PMASK)) begin
            per_q = PMASK;
        end else begin
            per_q = r_quo[PB-1:0];
        end
    end

    always_comb begin
        lo     = {r_min, 16'd0};
        hi     = {r_max, 16'd0};
        span   = hi - lo;
        cv_num = {(r_efix - lo), 16'd0} - NUM_W'(r_efix - lo);
        ph_inc = {1'b0, r_phase} + (PB+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (in_xfer && i_s_axis_tuser == OP_TICK) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: n_state = r_chg ? S_BNUM : S_PLOAD;
            S_BNUM:  n_state = (r_bd == '0) ? S_PLOAD : S_BEAT;
            S_BEAT:  n_state = (r_cnt == CNT_W'(1)) ? S_BEND : S_BEAT;
            S_BEND:  n_state = S_PLOAD;
            S_PLOAD: n_state = (r_bd == '0) ? S_CV : S_PER;
            S_PER:   n_state = (r_cnt == CNT_W'(1)) ? S_PEND : S_PER;
            S_PEND:  n_state = S_MUL;
            S_MUL:   n_state = (r_cnt == CNT_W'(1)) ? S_MEND : S_MUL;
            S_MEND:  n_state = (DW'(r_m) >= r_rem[DW-1:0]) ? S_CV : S_EDIV;
            S_EDIV:  n_state = (r_cnt == CNT_W'(1)) ? S_EEND : S_EDIV;
            S_EEND:  n_state = S_CV;
            S_CV: begin
                if (r_max <= r_min || r_sat || r_efix >= hi || r_efix <= lo) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_CDIV;
                end
            end
            S_CDIV:  n_state = (r_cnt == CNT_W'(1)) ? S_CEND : S_CDIV;
            S_CEND:  n_state = S_OUT;
            S_OUT:   n_state = out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr     <= SR_W'(48000);
            r_manual <= BPM_W'(30720);
            r_min    <= '0;
            r_max    <= MS_W'(1000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SAMPLE_RATE: r_sr     <= i_cfg_data;
                REG_MANUAL_BPM:  r_manual <= i_cfg_data[BPM_W-1:0];
                REG_MIN_MS:      r_min    <= i_cfg_data[MS_W-1:0];
                REG_MAX_MS:      r_max    <= i_cfg_data[MS_W-1:0];
                default: ;
            endcase
        end
    end

    // block state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpm        <= BPM_W'(30720);
            r_speed      <= '0;
            r_last_speed <= '0;
            r_beat       <= '0;
            r_last_sync  <= 1'b0;
            r_div        <= DIV_W'(256);
            r_phase      <= '0;
            r_chg        <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (in_xfer) begin
                if (i_s_axis_tuser == OP_UPDATE) begin
                    if (in_bpm_v)  r_bpm   <= in_bpm;
                    if (in_spd_v)  r_speed <= in_spd;
                    if (in_beat_v) r_beat  <= in_beat;
                end else begin
                    if (!in_sync) r_bpm <= r_manual;
                    r_chg <= (r_speed != r_last_speed) || (in_sync != r_last_sync)
                             || (in_div != r_div);
                    r_last_speed <= r_speed;
                    r_last_sync  <= in_sync;
                    r_div        <= in_div;
                end
            end
            if (r_state == S_BNUM && r_bd == '0) begin
                r_phase <= '0;
            end
            if (r_state == S_BEND) begin
                r_phase <= (r_quo > NUM_W'(PMASK)) ? PMASK : r_quo[PB-1:0];
            end
            if (r_state == S_OUT && out_free) begin
                // advance and wrap at the end of the period
                r_phase  <= (ph_inc >= {1'b0, r_period}) ? '0 : ph_inc[PB-1:0];
            end
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_SETUP: begin
                r_k  <= K_W'(r_sr) * K_W'(60);
                r_bd <= BD_W'(r_bpm) * BD_W'(r_div);
                r_pd <= BEAT_W'(r_beat * BEAT_W'(r_div));
            end
            S_BNUM: begin
                r_rem <= '0;
                r_quo <= '0;
                r_num <= NUM_W'(r_k) * NUM_W'(r_pd);
                r_dvs <= DW'({r_bd, 8'd0});
                r_cnt <= CNT_W'(NUM_W);
            end
            S_PLOAD: begin
                r_period <= PB'(1);
                r_efix   <= '0;
                r_sat    <= 1'b0;
                r_rem    <= '0;
                r_quo    <= '0;
                r_num    <= {r_k, 24'd0};
                r_dvs    <= DW'(r_bd);
                r_cnt    <= CNT_W'(PER_NUM_W);
            end
            S_BEAT, S_PER, S_EDIV, S_CDIV: begin
                r_rem <= st_rem;
                r_quo <= st_quo;
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            S_PEND: begin
                r_period <= per_q;
                r_m      <= MW'(r_phase) * MW'(60000);
                r_rem    <= '0;
                r_num    <= {per_q, {(NUM_W-PB){1'b0}}};
                r_cnt    <= CNT_W'(PB);
            end
            S_MUL: begin
                r_rem <= mul_acc;
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            S_MEND: begin
                r_dvs <= r_rem[DW-1:0];
                if (DW'(r_m) >= r_rem[DW-1:0]) begin
                    r_sat  <= 1'b1;
                    r_efix <= '1;
                end else begin
                    r_rem <= RW'(r_m);
                    r_quo <= '0;
                    r_num <= '0;
                    r_cnt <= CNT_W'(EFIX_W);
                end
            end
            S_EEND: r_efix <= r_quo[EFIX_W-1:0];
            S_CV: begin
                if (r_max <= r_min || r_efix <= lo) begin
                    r_cv <= '0;
                end else if (r_sat || r_efix >= hi) begin
                    r_cv <= '1;
                end else begin
                    r_rem <= '0;
                    r_quo <= '0;
                    r_num <= cv_num;
                    r_dvs <= DW'(span);
                    r_cnt <= CNT_W'(NUM_W);
                end
            end
            S_CEND: r_cv <= r_quo[MS_W-1:0];
            S_OUT: begin
                if (out_free) begin
                    r_odata <= {(r_sat ? 16'hFFFF : r_efix[31:16]), r_cv};
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    a_period_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> r_period != '0)
        else $error("period is zero at result");

    a_iter_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BEAT || r_state == S_PER || r_state == S_MUL
         || r_state == S_EDIV || r_state == S_CDIV) |-> r_cnt != '0)
        else $error("iteration count ran out");

    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_s_axis_tuser == OP_TICK |=> r_state == S_SETUP)
        else $error("tick did not start the sequence");

endmodule
